@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the lottery cpu scheduler.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int OP_W   = 2;
	localparam int CPU_W  = 2;
	localparam int PID_W  = 10;
	localparam int DRAW_W = 16;
	localparam int QL_W   = 8;
	localparam int DCNT_W = $clog2(DRAW_W + 1);

	localparam logic [QL_W-1:0] QUANTUM_RESET = 8'd10;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_TICK  = 2'd1,
		OP_BLOCK = 2'd2,
		OP_EXIT  = 2'd3
	} op_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_EVAL = 9'b000000010,
		S_DIV  = 9'b000000100,
		S_PICK = 9'b000001000,
		S_RWIN = 9'b000010000,
		S_SHRD = 9'b000100000,
		S_SHWR = 9'b001000000,
		S_FIN  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic in_rdy;
		logic add;
		logic set_idle;
		logic tick_dec;
		logic div_start;
		logic div_req;
		logic keep;
		logic pick_rd;
		logic win_latch;
		logic sh_rd;
		logic sh_wr;
		logic fin;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_acc;
		logic is_add;
		logic is_tick;
		logic cpu_ok;
		logic cpu_idle;
		logic expire;
		logic pool_empty;
		logic div_busy;
		logic keep_cur;
		logic more_shift;
		logic out_free;
	} dp_sts_t;

endpackage

@@ rtl/lcs_evt_if.sv @@
// ----------------------------------------------------------------------------
// lcs_evt_if
// Event channel: one scheduler event word per handshake.
// ----------------------------------------------------------------------------
interface lcs_evt_if;
	logic                         valid;
	logic                         ready;
	logic [lcs_pkg::OP_W-1:0]     op;
	logic [lcs_pkg::CPU_W-1:0]    cpu;
	logic [lcs_pkg::PID_W-1:0]    pid;
	logic [lcs_pkg::DRAW_W-1:0]   draw;

	modport source (output valid, op, cpu, pid, draw, input ready);
	modport sink (input valid, op, cpu, pid, draw, output ready);
endinterface

@@ rtl/lcs_res_if.sv @@
// ----------------------------------------------------------------------------
// lcs_res_if
// Result channel: one scheduling decision word per handshake.
// ----------------------------------------------------------------------------
interface lcs_res_if;
	logic                        valid;
	logic                        ready;
	logic [lcs_pkg::PID_W-1:0]   next_task;
	logic                        idle;
	logic                        status;

	modport source (output valid, next_task, idle, status, input ready);
	modport sink (input valid, next_task, idle, status, output ready);
endinterface

@@ rtl/lcs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lcs_cfg_if
// Configuration write channel for the quantum length register.
// ----------------------------------------------------------------------------
interface lcs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lcs_pkg::QL_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/lcs_mod.sv @@
// ----------------------------------------------------------------------------
// lcs_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lcs_mod #(
	parameter int DW = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lcs_pkg::DRAW_W-1:0]   num,
	input  logic [DW-1:0]                den,
	output logic                         busy,
	output logic [DW-1:0]                rem
);

	logic                          busy_q;
	logic [lcs_pkg::DCNT_W-1:0]    cnt_q;
	logic [lcs_pkg::DRAW_W-1:0]    num_q;
	logic [DW-1:0]                 den_q;
	logic [DW-1:0]                 rem_q;
	logic [DW:0]                   trial;
	logic [DW:0]                   diff;
	logic                          ge;

	assign trial = {rem_q, num_q[lcs_pkg::DRAW_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= lcs_pkg::DCNT_W'(lcs_pkg::DRAW_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == lcs_pkg::DCNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[lcs_pkg::DRAW_W-2:0], 1'b0};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

@@ rtl/lcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: decode, draw, pool compaction and result hand-off.
// ----------------------------------------------------------------------------
module lcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  lcs_pkg::dp_sts_t   sts,
	output lcs_pkg::dp_cmd_t   cmd
);

	lcs_pkg::state_t state_q;
	lcs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lcs_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			lcs_pkg::S_IDLE: begin
				cmd.in_rdy = 1'b1;
				if (sts.in_acc)
					state_d = lcs_pkg::S_EVAL;
			end
			lcs_pkg::S_EVAL: begin
				state_d = lcs_pkg::S_OUT;
				if (sts.is_add) begin
					cmd.add = 1'b1;
				end else if (!sts.cpu_ok) begin
					state_d = lcs_pkg::S_OUT;
				end else if (sts.is_tick && !sts.cpu_idle) begin
					if (sts.expire) begin
						cmd.div_start = 1'b1;
						cmd.div_req   = 1'b1;
						state_d       = lcs_pkg::S_DIV;
					end else begin
						cmd.tick_dec = 1'b1;
					end
				end else if (sts.pool_empty) begin
					cmd.set_idle = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = lcs_pkg::S_DIV;
				end
			end
			lcs_pkg::S_DIV: begin
				if (!sts.div_busy)
					state_d = lcs_pkg::S_PICK;
			end
			lcs_pkg::S_PICK: begin
				if (sts.keep_cur) begin
					cmd.keep = 1'b1;
					state_d  = lcs_pkg::S_OUT;
				end else begin
					cmd.pick_rd = 1'b1;
					state_d     = lcs_pkg::S_RWIN;
				end
			end
			lcs_pkg::S_RWIN: begin
				cmd.win_latch = 1'b1;
				state_d       = lcs_pkg::S_SHRD;
			end
			lcs_pkg::S_SHRD: begin
				if (sts.more_shift) begin
					cmd.sh_rd = 1'b1;
					state_d   = lcs_pkg::S_SHWR;
				end else begin
					state_d = lcs_pkg::S_FIN;
				end
			end
			lcs_pkg::S_SHWR: begin
				cmd.sh_wr = 1'b1;
				state_d   = lcs_pkg::S_SHRD;
			end
			lcs_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				state_d = lcs_pkg::S_OUT;
			end
			lcs_pkg::S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = lcs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lcs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/lcs_dp.sv @@
// ----------------------------------------------------------------------------
// lcs_dp
// Datapath: ready pool memory, per-cpu state, draw remainder and result word.
// ----------------------------------------------------------------------------
module lcs_dp #(
	parameter int MAX_TASKS = 32,
	parameter int NUM_CPUS  = 4,
	parameter int PID_BITS  = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	lcs_evt_if.sink            evt,
	lcs_res_if.source          res,
	lcs_cfg_if.sink            cfg,
	input  lcs_pkg::dp_cmd_t   cmd,
	output lcs_pkg::dp_sts_t   sts
);

	localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW  = $clog2(MAX_TASKS + 1);
	localparam int DW  = $clog2(MAX_TASKS + 2);
	localparam int CPW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

	logic [lcs_pkg::OP_W-1:0]     op_q;
	logic [lcs_pkg::CPU_W-1:0]    cpu_q;
	logic [PID_BITS-1:0]          pid_q;
	logic [lcs_pkg::DRAW_W-1:0]   draw_q;
	logic [lcs_pkg::QL_W-1:0]     ql_q;
	logic [CW-1:0]                count_q;
	logic                         full_q;
	logic                         req_q;
	logic [AW-1:0]                idx_q;
	logic [PID_BITS-1:0]          win_q;
	logic [PID_BITS-1:0]          rdata_q;
	logic [PID_BITS-1:0]          pool_mem [MAX_TASKS];

	logic [PID_BITS-1:0]          run_q   [NUM_CPUS];
	logic                         idle_q  [NUM_CPUS];
	logic [lcs_pkg::QL_W-1:0]     quant_q [NUM_CPUS];

	logic                         out_valid_q;
	logic [lcs_pkg::PID_W-1:0]    out_task_q;
	logic                         out_idle_q;
	logic                         out_status_q;

	logic [CPW-1:0]               c_idx;
	logic                         cpu_ok;
	logic                         is_add;
	logic                         full;
	logic [PID_BITS-1:0]          cur_run;
	logic                         cur_idle;
	logic [lcs_pkg::QL_W-1:0]     cur_quant;
	logic [DW-1:0]                den;
	logic [DW-1:0]                rem;
	logic                         div_busy;
	logic [CW:0]                  idx_nxt;
	logic                         mem_we;
	logic [AW-1:0]                mem_wa;
	logic [PID_BITS-1:0]          mem_wd;
	logic                         mem_re;
	logic [AW-1:0]                mem_ra;
	logic                         in_acc;

	assign in_acc    = evt.valid && evt.ready;
	assign evt.ready = cmd.in_rdy;
	assign cfg.ready = 1'b1;

	assign is_add    = op_q == lcs_pkg::OP_ADD;
	assign cpu_ok    = int'(cpu_q) < NUM_CPUS;
	assign c_idx     = CPW'(cpu_q);
	assign cur_run   = run_q[c_idx];
	assign cur_idle  = idle_q[c_idx];
	assign cur_quant = quant_q[c_idx];
	assign full      = count_q == CW'(MAX_TASKS);
	assign den       = DW'(count_q) + DW'(cmd.div_req);
	assign idx_nxt   = (CW+1)'(idx_q) + (CW+1)'(1);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= evt.op;
			cpu_q  <= evt.cpu;
			pid_q  <= PID_BITS'(evt.pid);
			draw_q <= evt.draw;
		end
		if (cmd.add)
			full_q <= full;
		if (cmd.div_start)
			req_q <= cmd.div_req;
		if (cmd.pick_rd)
			idx_q <= AW'(rem);
		else if (cmd.sh_wr)
			idx_q <= idx_q + 1'b1;
		if (cmd.win_latch)
			win_q <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ql_q <= lcs_pkg::QUANTUM_RESET;
		else if (cfg.valid && cfg.ready)
			ql_q <= cfg.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.add && !full)
			count_q <= count_q + 1'b1;
		else if (cmd.fin && !req_q)
			count_q <= count_q - 1'b1;
	end

	// pool memory: one write port, one registered read port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rdata_q;
		if (cmd.add && !full) begin
			mem_we = 1'b1;
			mem_wa = AW'(count_q);
			mem_wd = pid_q;
		end else if (cmd.sh_wr) begin
			mem_we = 1'b1;
		end else if (cmd.fin && req_q) begin
			mem_we = 1'b1;
			mem_wa = AW'(count_q - 1'b1);
			mem_wd = cur_run;
		end
	end

	assign mem_re = cmd.pick_rd || cmd.sh_rd;
	assign mem_ra = cmd.pick_rd ? AW'(rem) : AW'(idx_nxt);

	always_ff @(posedge clk) begin
		if (mem_we)
			pool_mem[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= pool_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				run_q[i]   <= '0;
				idle_q[i]  <= 1'b1;
				quant_q[i] <= lcs_pkg::QUANTUM_RESET;
			end
		end else if (cmd.set_idle) begin
			run_q[c_idx]  <= '0;
			idle_q[c_idx] <= 1'b1;
		end else if (cmd.tick_dec) begin
			quant_q[c_idx] <= cur_quant - 1'b1;
		end else if (cmd.keep) begin
			idle_q[c_idx]  <= 1'b0;
			quant_q[c_idx] <= ql_q;
		end else if (cmd.fin) begin
			run_q[c_idx]   <= win_q;
			idle_q[c_idx]  <= 1'b0;
			quant_q[c_idx] <= ql_q;
		end
	end

	lcs_mod #(
		.DW(DW)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (draw_q),
		.den   (den),
		.busy  (div_busy),
		.rem   (rem)
	);

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= is_add && full_q;
			if (is_add) begin
				out_task_q <= '0;
				out_idle_q <= 1'b0;
			end else if (!cpu_ok || cur_idle) begin
				out_task_q <= '0;
				out_idle_q <= 1'b1;
			end else begin
				out_task_q <= lcs_pkg::PID_W'(cur_run);
				out_idle_q <= 1'b0;
			end
		end
	end

	assign res.valid     = out_valid_q;
	assign res.next_task = out_task_q;
	assign res.idle      = out_idle_q;
	assign res.status    = out_status_q;

	always_comb begin
		sts            = '0;
		sts.in_acc     = in_acc;
		sts.is_add     = is_add;
		sts.is_tick    = op_q == lcs_pkg::OP_TICK;
		sts.cpu_ok     = cpu_ok;
		sts.cpu_idle   = cur_idle;
		sts.expire     = cur_quant == lcs_pkg::QL_W'(1);
		sts.pool_empty = count_q == '0;
		sts.div_busy   = div_busy;
		sts.keep_cur   = req_q && (rem == DW'(count_q));
		sts.more_shift = idx_nxt < (CW+1)'(count_q);
		sts.out_free   = !out_valid_q || res.ready;
	end

`ifndef SYNTH
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_TASKS)
		else $error("pool count above capacity");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !evt.ready)
		else $error("event taken while another is in flight");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sh_wr |-> ((CW+1)'(idx_q) < (CW+1)'(count_q)))
		else $error("compaction write beyond pool fill");

	a_requeue_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && req_q) |=> count_q == $past(count_q))
		else $error("requeue changed pool count");
`endif

endmodule

@@ rtl/lottery_cpu_scheduler.sv @@
// add or non-expiring tick: event registered, decoded in EVAL, result loaded in OUT
// draw: remainder, winner read, later entries shift down; expired task kept in PICK
// the bit-serial remainder and the read-then-write pool shift set the rate
// one event in flight, next taken while the result word waits
// reset: pool empty, all cpus idle, quantum 10; pool contents unset, no clear pass
// ----------------------------------------------------------------------------
// lottery_cpu_scheduler
// Multi-cpu lottery scheduler with a shared ordered ready pool.
// ----------------------------------------------------------------------------
module lottery_cpu_scheduler #(
	parameter int MAX_TASKS = 32,
	parameter int NUM_CPUS  = 4,
	parameter int PID_BITS  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	lcs_evt_if.sink     evt,
	lcs_res_if.source   res,
	lcs_cfg_if.sink     cfg
);

	lcs_pkg::dp_cmd_t cmd;
	lcs_pkg::dp_sts_t sts;

	lcs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	lcs_dp #(
		.MAX_TASKS(MAX_TASKS),
		.NUM_CPUS (NUM_CPUS),
		.PID_BITS (PID_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.evt   (evt),
		.res   (res),
		.cfg   (cfg),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule
